// File: hw/rtl/length_prefixed_bit_packer_defines.svh
// Assertion macros used by the bit packer datapath.
`ifndef LENGTH_PREFIXED_BIT_PACKER_DEFINES_SVH
`define LENGTH_PREFIXED_BIT_PACKER_DEFINES_SVH

// Same-cycle implication, checked on clk and disabled while arst_n is low.
`define LPBP_ASSERT_IMPLY(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk and disabled while arst_n is low.
`define LPBP_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/lpbp_pkg.sv
// Command and status types shared by the bit packer controller and datapath.
package lpbp_pkg;

	localparam logic SEL_DATA   = 1'b0;
	localparam logic SEL_LENGTH = 1'b1;

	typedef struct packed {
		logic load;
		logic count;
		logic data_step;
		logic len_step;
		logic data_flush;
		logic len_flush;
	} lpbp_cmd_t;

	typedef struct packed {
		logic can_emit;
		logic count_zero;
		logic data_full;
		logic data_rem_last;
		logic len_emit;
		logic final_word;
	} lpbp_status_t;

endpackage

// File: hw/rtl/lpbp_ctrl.sv
// Sequencing state machine of the bit packer.
module lpbp_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  lpbp_pkg::lpbp_status_t status,
	output lpbp_pkg::lpbp_cmd_t    cmd
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_COUNT  = 6'b000010,
		ST_DATA   = 6'b000100,
		ST_LEN    = 6'b001000,
		ST_DFLUSH = 6'b010000,
		ST_LFLUSH = 6'b100000
	} lpbp_state_t;

	lpbp_state_t state_q;
	lpbp_state_t state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_COUNT;
				end
			end
			ST_COUNT: begin
				cmd.count = 1'b1;
				state_d   = status.count_zero ? ST_LEN : ST_DATA;
			end
			ST_DATA: begin
				if (!status.data_full || status.can_emit) begin
					cmd.data_step = 1'b1;
					if (status.data_rem_last) begin
						state_d = ST_LEN;
					end
				end
			end
			ST_LEN: begin
				if (!status.len_emit || status.can_emit) begin
					cmd.len_step = 1'b1;
					state_d      = status.final_word ? ST_DFLUSH : ST_IDLE;
				end
			end
			ST_DFLUSH: begin
				if (status.can_emit) begin
					cmd.data_flush = 1'b1;
					state_d        = ST_LFLUSH;
				end
			end
			ST_LFLUSH: begin
				if (status.can_emit) begin
					cmd.len_flush = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == ST_IDLE);

endmodule

// File: hw/rtl/lpbp_datapath.sv
// Bit counting, byte accumulators and output register of the bit packer.
module lpbp_datapath #(
	parameter int WORD_BITS   = 32,
	parameter int LENGTH_BITS = 6
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lpbp_pkg::lpbp_cmd_t     cmd,
	output lpbp_pkg::lpbp_status_t  status,
	input  logic [WORD_BITS-1:0]   word_value,
	input  logic                   final_word,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   out_select,
	output logic [7:0]             out_byte,
	output logic                   out_last,
	output logic                   out_end
);

	`include "length_prefixed_bit_packer_defines.svh"

	localparam int CW   = $clog2(WORD_BITS + 1);
	localparam int NB   = (WORD_BITS + 7) / 8;
	localparam int TW   = (NB > 1) ? $clog2(NB) : 1;
	localparam int CMPW = (CW > LENGTH_BITS) ? CW : LENGTH_BITS;
	localparam logic [CMPW-1:0] LMAX = CMPW'((1 << LENGTH_BITS) - 1);
	localparam logic [3:0]      LB   = 4'(LENGTH_BITS);

	logic [WORD_BITS-1:0] word_q;
	logic                 final_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        rem_q;
	logic [7:0]           dacc_q;
	logic [3:0]           dfill_q;
	logic [7:0]           lacc_q;
	logic [3:0]           lfill_q;
	logic                 oval_q;
	logic                 osel_q;
	logic [7:0]           obyte_q;
	logic                 olast_q;
	logic                 oend_q;

	// leading-one search: pick the top nonzero byte, then the top bit inside it
	logic [NB*8-1:0] padded;
	logic [NB-1:0]   byte_nz;
	logic [TW-1:0]   top;
	logic [7:0]      top_byte;
	logic [2:0]      pos;
	logic [CW-1:0]   count_d;

	always_comb begin
		padded = (NB*8)'(word_q);
		for (int b = 0; b < NB; b++) begin
			byte_nz[b] = |padded[b*8 +: 8];
		end
		top = '0;
		for (int b = 0; b < NB; b++) begin
			if (byte_nz[b]) begin
				top = TW'(b);
			end
		end
		top_byte = padded[top*8 +: 8];
		pos = '0;
		for (int j = 0; j < 8; j++) begin
			if (top_byte[j]) begin
				pos = 3'(j);
			end
		end
		count_d = (|byte_nz) ? CW'({top, pos}) + CW'(1) : '0;
	end

	// data stream step
	logic           data_full;
	logic [3:0]     space;
	logic [3:0]     dk;
	logic [CW-1:0]  shamt;
	logic [7:0]     chunk;
	logic [7:0]     dacc_d;
	logic [3:0]     dfill_d;
	logic           rem_last;

	always_comb begin
		data_full = (dfill_q == 4'd8);
		space     = data_full ? 4'd8 : 4'd8 - dfill_q;
		dk        = (rem_q < CW'(space)) ? 4'(rem_q) : space;
		shamt     = rem_q - CW'(dk);
		chunk     = 8'(word_q >> shamt) & ((8'd1 << dk) - 8'd1);
		dacc_d    = data_full ? chunk : (8'(dacc_q << dk) | chunk);
		dfill_d   = data_full ? dk : dfill_q + dk;
		rem_last  = (rem_q == CW'(dk));
	end

	// length stream step
	logic [CMPW-1:0]        cnt_ext;
	logic [LENGTH_BITS-1:0] len_val;
	logic [7:0]             len_byte;
	logic [4:0]             lsum;
	logic                   len_emit;
	logic [3:0]             lsp;
	logic [3:0]             lrest;
	logic [7:0]             len_out_byte;
	logic [7:0]             lacc_d;
	logic [3:0]             lfill_d;

	always_comb begin
		cnt_ext      = CMPW'(count_q);
		len_val      = (cnt_ext > LMAX) ? LENGTH_BITS'(LMAX) : LENGTH_BITS'(cnt_ext);
		len_byte     = 8'(len_val);
		lsum         = 5'(lfill_q) + 5'(LB);
		len_emit     = (lsum > 5'd8);
		lsp          = 4'd8 - lfill_q;
		lrest        = LB - lsp;
		len_out_byte = 8'(lacc_q << lsp) | 8'(len_byte >> lrest);
		if (len_emit) begin
			lacc_d  = len_byte & ((8'd1 << lrest) - 8'd1);
			lfill_d = lrest;
		end else begin
			lacc_d  = 8'(lacc_q << LB) | len_byte;
			lfill_d = 4'(lsum);
		end
	end

	// result selection
	logic       can_emit;
	logic       emit;
	logic       e_sel;
	logic [7:0] e_byte;
	logic       e_last;
	logic       e_end;

	always_comb begin
		can_emit = !oval_q || out_ready;
		emit     = 1'b0;
		e_sel    = lpbp_pkg::SEL_DATA;
		e_byte   = dacc_q;
		e_last   = 1'b0;
		e_end    = 1'b0;
		if (cmd.data_step && data_full) begin
			emit   = 1'b1;
			e_last = !final_q && !len_emit && rem_last;
		end else if (cmd.len_step && len_emit) begin
			emit   = 1'b1;
			e_sel  = lpbp_pkg::SEL_LENGTH;
			e_byte = len_out_byte;
			e_last = !final_q;
		end else if (cmd.data_flush) begin
			emit   = 1'b1;
			e_byte = 8'(dacc_q << (4'd8 - dfill_q));
			e_end  = 1'b1;
		end else if (cmd.len_flush) begin
			emit   = 1'b1;
			e_sel  = lpbp_pkg::SEL_LENGTH;
			e_byte = 8'(lacc_q << (4'd8 - lfill_q));
			e_last = 1'b1;
			e_end  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dacc_q  <= '0;
			dfill_q <= '0;
			lacc_q  <= '0;
			lfill_q <= '0;
			oval_q  <= 1'b0;
		end else begin
			if (cmd.data_step) begin
				dacc_q  <= dacc_d;
				dfill_q <= dfill_d;
			end else if (cmd.data_flush) begin
				dacc_q  <= '0;
				dfill_q <= '0;
			end
			if (cmd.len_step) begin
				lacc_q  <= lacc_d;
				lfill_q <= lfill_d;
			end else if (cmd.len_flush) begin
				lacc_q  <= '0;
				lfill_q <= '0;
			end
			if (emit) begin
				oval_q <= 1'b1;
			end else if (out_ready) begin
				oval_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			word_q  <= word_value;
			final_q <= final_word;
		end
		if (cmd.count) begin
			count_q <= count_d;
			rem_q   <= count_d;
		end else if (cmd.data_step) begin
			rem_q <= rem_q - CW'(dk);
		end
		if (emit) begin
			osel_q  <= e_sel;
			obyte_q <= e_byte;
			olast_q <= e_last;
			oend_q  <= e_end;
		end
	end

	always_comb begin
		status.can_emit      = can_emit;
		status.count_zero    = (count_d == '0);
		status.data_full     = data_full;
		status.data_rem_last = rem_last;
		status.len_emit      = len_emit;
		status.final_word    = final_q;
	end

	assign out_valid  = oval_q;
	assign out_select = osel_q;
	assign out_byte   = obyte_q;
	assign out_last   = olast_q;
	assign out_end    = oend_q;

	`LPBP_ASSERT_IMPLY(a_emit_room, emit, can_emit, "beat emitted into occupied output register")
	`LPBP_ASSERT_IMPLY(a_step_bits, cmd.data_step, rem_q != '0, "data step with no bits left")
	`LPBP_ASSERT_IMPLY(a_fill_range, 1'b1, (dfill_q <= 4'd8) && (lfill_q <= 4'd8), "fill out of range")
	`LPBP_ASSERT_NEXT(a_flush_clear, cmd.len_flush, (dfill_q == 4'd0) && (lfill_q == 4'd0), "streams not empty after flush")

endmodule

// File: hw/rtl/length_prefixed_bit_packer.sv
// Length-prefixed bit packer: word bits to a data byte stream, bit counts to a length stream.
// A word passes through these steps from acceptance: load, find the bit count, one step per data
// byte chunk (0 to 5 at the default width), one for the length bits, and on a final word a data
// flush and a length flush; stalls on the output beat register hold these steps.
// Results leave through a one-beat output register; the next word is taken once the last step ends.
// Reset clears the sequencer, both byte accumulators and their fill counts, and the output valid.
module length_prefixed_bit_packer #(
	parameter int WORD_BITS   = 32,
	parameter int LENGTH_BITS = 6
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [((WORD_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata, // word_value
	input  logic                                s_axis_tlast,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [7:0]                          m_axis_tdata, // byte_out
	output logic [1:0]                          m_axis_tuser, // stream_select, stream_end
	output logic                                m_axis_tlast
);

	lpbp_pkg::lpbp_cmd_t    cmd;
	lpbp_pkg::lpbp_status_t status;
	logic                   out_select;
	logic                   out_end;

	lpbp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	lpbp_datapath #(
		.WORD_BITS   (WORD_BITS),
		.LENGTH_BITS (LENGTH_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.word_value (s_axis_tdata[WORD_BITS-1:0]),
		.final_word (s_axis_tlast),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_select (out_select),
		.out_byte   (m_axis_tdata),
		.out_last   (m_axis_tlast),
		.out_end    (out_end)
	);

	assign m_axis_tuser = {out_end, out_select};

endmodule

// File: tb/sv/packed_stream_checker.sv
// Checker for the length-prefixed bit packer: predicts byte beats from accepted words and compares.
module packed_stream_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        word_valid,
	input  logic        word_ready,
	input  logic [31:0] word_data,
	input  logic        word_last,
	input  logic        beat_valid,
	input  logic        beat_ready,
	input  logic [7:0]  beat_data,
	input  logic [1:0]  beat_user,
	input  logic        beat_last,
	output int          mismatches,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic       sel;
		logic [7:0] value;
		logic       run_last;
		logic       stream_end;
	} out_beat_t;

	out_beat_t  pending_beats[$];
	out_beat_t  word_beats[$];
	logic [7:0] accum [2] = '{8'h00, 8'h00};
	logic [3:0] fill  [2] = '{4'd0, 4'd0};

	initial begin
		mismatches  = 0;
		outstanding = 0;
	end

	function automatic void emit_beat(logic sel, logic [7:0] value, logic stream_end);
		out_beat_t b;
		b.sel        = sel;
		b.value      = value;
		b.run_last   = 1'b0;
		b.stream_end = stream_end;
		word_beats.push_back(b);
	endfunction

	function automatic void add_bit(logic sel, logic bit_val);
		if (fill[sel] >= 4'd8) begin
			emit_beat(sel, accum[sel], 1'b0);
			accum[sel] = 8'h00;
			fill[sel]  = 4'd0;
		end
		accum[sel] = {accum[sel][6:0], bit_val};
		fill[sel]  = fill[sel] + 4'd1;
	endfunction

	function automatic void flush_stream(logic sel);
		logic [7:0] aligned;
		aligned = (fill[sel] >= 4'd8) ? accum[sel] : (accum[sel] << (4'd8 - fill[sel]));
		emit_beat(sel, aligned, 1'b1);
		accum[sel] = 8'h00;
		fill[sel]  = 4'd0;
	endfunction

	function automatic void pack_word(logic [31:0] word, logic is_final);
		int         nbits;
		logic [5:0] bit_count;
		out_beat_t  b;
		word_beats.delete();
		nbits = 0;
		for (int i = 0; i < 32; i++) begin
			if (word[i]) begin
				nbits = i + 1;
			end
		end
		for (int i = nbits - 1; i >= 0; i--) begin
			add_bit(lpbp_pkg::SEL_DATA, word[i]);
		end
		bit_count = 6'(nbits);
		for (int i = 5; i >= 0; i--) begin
			add_bit(lpbp_pkg::SEL_LENGTH, bit_count[i]);
		end
		if (is_final) begin
			flush_stream(lpbp_pkg::SEL_DATA);
			flush_stream(lpbp_pkg::SEL_LENGTH);
		end
		foreach (word_beats[i]) begin
			b          = word_beats[i];
			b.run_last = (i == word_beats.size() - 1);
			pending_beats.push_back(b);
		end
	endfunction

	function automatic void report(string msg);
		if (mismatches < 10) begin
			$display("%0t: %s", $realtime, msg);
		end
		mismatches = mismatches + 1;
	endfunction

	always @(posedge clk) begin
		out_beat_t got;
		out_beat_t want;
		if (arst_n) begin
			if (beat_valid && beat_ready) begin
				got.sel        = beat_user[0];
				got.value      = beat_data;
				got.run_last   = beat_last;
				got.stream_end = beat_user[1];
				if (pending_beats.size() == 0) begin
					report($sformatf("unexpected beat sel=%0d byte=%02h last=%0d end=%0d",
						got.sel, got.value, got.run_last, got.stream_end));
				end else begin
					want = pending_beats.pop_front();
					if (got != want) begin
						report($sformatf({"beat mismatch: expected sel=%0d byte=%02h last=%0d ",
							"end=%0d, got sel=%0d byte=%02h last=%0d end=%0d"},
							want.sel, want.value, want.run_last, want.stream_end,
							got.sel, got.value, got.run_last, got.stream_end));
					end
				end
			end
			if (word_valid && word_ready) begin
				pack_word(word_data, word_last);
			end
		end
		outstanding <= pending_beats.size();
	end

endmodule

// File: tb/sv/length_prefixed_bit_packer_test.sv
// Testbench top for the length-prefixed bit packer: clock, reset, word stimulus and verdict.
module length_prefixed_bit_packer_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 3000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;
	int          mismatches;
	int          outstanding;
	int          idle_cycles = 0;
	logic        quiet_sender = 1'b0;

	always #10 clk = ~clk;

	length_prefixed_bit_packer u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	packed_stream_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.word_valid  (s_axis_tvalid),
		.word_ready  (s_axis_tready),
		.word_data   (s_axis_tdata),
		.word_last   (s_axis_tlast),
		.beat_valid  (m_axis_tvalid),
		.beat_ready  (m_axis_tready),
		.beat_data   (m_axis_tdata),
		.beat_user   (m_axis_tuser),
		.beat_last   (m_axis_tlast),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [31:0] random_word();
		int          nbits;
		logic [63:0] mask;
		if ($urandom_range(0, 9) == 0) begin
			nbits = ($urandom_range(0, 1) == 0) ? 0 : 32;
		end else begin
			nbits = $urandom_range(0, 32);
		end
		if (nbits == 0) begin
			return 32'h0;
		end
		mask = (64'd1 << nbits) - 64'd1;
		return 32'(((64'($urandom()) & mask) | (64'd1 << (nbits - 1))));
	endfunction

	task automatic send_word(logic [31:0] word, logic is_final);
		int gap;
		gap = quiet_sender ? 0 : pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= word;
		s_axis_tlast  <= is_final;
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
	endtask

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int stall;
		m_axis_tready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if ($urandom_range(0, 14) == 0) begin
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(30, 80)) @(posedge clk);
			end
			stall = pick_gap();
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	initial begin
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= 32'h0;
		s_axis_tlast  <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty data stream at flush, then exactly full bytes on both streams
		send_word(32'h0000_0000, 1'b0);
		send_word(32'h0000_0000, 1'b1);
		send_word(32'h0000_0000, 1'b0);
		send_word(32'h0000_0000, 1'b0);
		send_word(32'h0000_0000, 1'b0);
		send_word(32'h0000_00FF, 1'b1);
		send_word(32'hFFFF_FFFF, 1'b1);
		send_word(32'h8000_0000, 1'b0);
		send_word(32'h0000_0001, 1'b0);
		send_word(32'h7FFF_FFFF, 1'b0);
		send_word(32'hAAAA_AAAA, 1'b0);
		send_word(32'h5555_5555, 1'b1);
		send_word(32'h0000_0001, 1'b1);
		send_word(32'h1234_5678, 1'b0);
		send_word(32'hFFFF_FFFF, 1'b0);
		send_word(32'h8000_0001, 1'b1);
		send_word(32'h0000_0000, 1'b1);
		send_word(32'hFFFF_FFFF, 1'b0);
		send_word(32'hFFFF_FFFF, 1'b0);
		send_word(32'h0000_0003, 1'b1);

		for (int i = 0; i < 150; i++) begin
			quiet_sender <= ((i % 50) < 12);
			send_word(random_word(), ($urandom_range(0, 7) == 0));
		end
		send_word(random_word(), 1'b1);
		s_axis_tvalid <= 1'b0;

		do @(posedge clk); while (outstanding != 0);
		repeat (30) @(posedge clk);
		if (mismatches == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
